[rtl/ets_pkg.sv]
// ets_pkg: shared widths, codes and transfer types of the elapsed time statistics block
// no dependencies; imported by ets_div, ets_mul and elapsed_time_statistics
`timescale 1ns / 1ps
`default_nettype none

package ets_pkg;

    // sample counter width, 8 to 64
    localparam int COUNT_BITS = 32;

    // field widths
    localparam int TIME_W   = 30;
    localparam int SUM_W    = 64;
    localparam int DELAY_W  = 20;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 32;

    // shared multiplier operand width
    localparam int MUL_W = 32;

    // divider: one quotient bit per step
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [31:0] ONE_SECOND_NS = 32'd1000000000;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REPORT = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP    = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SAT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FEW = 2'd2;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [SUM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage : ets_pkg

`default_nettype wire

[rtl/ets_div.sv]
// ets_div: restoring unsigned divider, one quotient bit per cycle
// depends on ets_pkg (widths, t_div_req, t_div_rsp)
`timescale 1ns / 1ps
`default_nettype none

module ets_div
    import ets_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_rem;
    logic [SUM_W-1:0]     r_quo;
    logic [SUM_W-1:0]     r_dvs;

    logic [SUM_W:0]       shifted;
    logic [SUM_W:0]       trial;
    logic                 fits;

    // one restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        shifted = {r_rem, r_quo[SUM_W-1]};
        trial   = shifted - {1'b0, r_dvs};
        fits    = !trial[SUM_W];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? trial[SUM_W-1:0] : shifted[SUM_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule : ets_div

`default_nettype wire

[rtl/ets_mul.sv]
// ets_mul: shared 32 x 32 multiplier with registered product
// depends on ets_pkg (MUL_W)
`timescale 1ns / 1ps
`default_nettype none

module ets_mul
    import ets_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic [MUL_W-1:0]   i_op_a,
    input  wire logic [MUL_W-1:0]   i_op_b,
    output logic      [2*MUL_W-1:0] o_product
);

    logic [2*MUL_W-1:0] r_product;

    // product register
    always_ff @(posedge i_clk) begin
        r_product <= (2*MUL_W)'(i_op_a) * (2*MUL_W)'(i_op_b);
    end

    assign o_product = r_product;

endmodule : ets_mul

`default_nettype wire

[rtl/elapsed_time_statistics.sv]
// elapsed_time_statistics: elapsed time accumulator with min, max, sums and variance report
// depends on ets_pkg, ets_div and ets_mul
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_stall   i_action, i_begin_ns, i_end_ns
//   out      source     o_out_valid / i_out_stall elapsed, sums, min, max, count, variance
//   cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_read_delay
//
// sample: difference, square on the shared multiplier, accumulate, result.
// clear, no-op and a report with fewer than two samples: straight to the result. report:
// three 64-step divisions on the shared divider followed by four partial products on
// the shared multiplier.
// one transaction is in work at a time; o_in_stall is high until its result is registered.
// a result waits in the output register while i_out_stall is high; the next transaction
// may be taken meanwhile and holds in its last step until the register frees.
// reset is synchronous, active low; it clears the accumulators and read_delay.
`timescale 1ns / 1ps
`default_nettype none

module elapsed_time_statistics
    import ets_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input channel
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [ACTION_W-1:0] i_action,
    input  wire logic [TIME_W-1:0]   i_begin_ns,
    input  wire logic [TIME_W-1:0]   i_end_ns,
    // output channel
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [TIME_W-1:0]   o_elapsed,
    output logic      [SUM_W-1:0]    o_running_total,
    output logic      [SUM_W-1:0]    o_square_sum,
    output logic      [TIME_W-1:0]   o_least_time,
    output logic      [TIME_W-1:0]   o_greatest_time,
    output logic      [COUNT_W-1:0]  o_count_seen,
    output logic      [SUM_W-1:0]    o_variance_out,
    output logic      [STATUS_W-1:0] o_status,
    // configuration
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [DELAY_W-1:0]  i_cfg_read_delay
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR,
        ST_ACC,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_MUL,
        ST_VAR,
        ST_DONE
    } t_state;

    // which division is running
    localparam logic [1:0] DIV_MSQ = 2'd0;
    localparam logic [1:0] DIV_Q1  = 2'd1;
    localparam logic [1:0] DIV_Q2  = 2'd2;

    t_state               r_state;
    logic [DELAY_W-1:0]   r_read_delay;

    // accumulators
    logic [SUM_W-1:0]      r_total;
    logic [SUM_W-1:0]      r_sumsq;
    logic [TIME_W-1:0]     r_min;
    logic [TIME_W-1:0]     r_max;
    logic [COUNT_BITS-1:0] r_count;

    // per-transaction working registers
    logic [TIME_W-1:0]    r_elapsed;
    logic                 r_flag;
    logic [STATUS_W-1:0]  r_status;
    logic [SUM_W-1:0]     r_var;
    logic [1:0]           r_div_sel;
    logic [SUM_W-1:0]     r_msq;
    logic [SUM_W-1:0]     r_q1;
    logic [SUM_W-1:0]     r_q2;
    logic [2:0]           r_pp;
    logic [2*SUM_W-1:0]   r_acc;

    // output register
    logic                 r_out_valid;
    logic [TIME_W-1:0]    r_o_elapsed;
    logic [SUM_W-1:0]     r_o_total;
    logic [SUM_W-1:0]     r_o_sumsq;
    logic [TIME_W-1:0]    r_o_min;
    logic [TIME_W-1:0]    r_o_max;
    logic [COUNT_W-1:0]   r_o_count;
    logic [SUM_W-1:0]     r_o_var;
    logic [STATUS_W-1:0]  r_o_status;

    logic                 in_take;
    logic                 out_free;
    logic [31:0]          gap;
    logic [31:0]          t_corr;
    logic [TIME_W-1:0]    elapsed_now;
    logic                 elapsed_neg;
    logic [SUM_W-1:0]     count_ext;
    logic [SUM_W-1:0]     count_m1;
    logic [SUM_W:0]       total_add;
    logic [SUM_W:0]       sumsq_add;
    logic                 count_full;
    logic [MUL_W-1:0]     mul_a;
    logic [MUL_W-1:0]     mul_b;
    logic [2*MUL_W-1:0]   mul_product;
    logic [2:0]           pp_prev;
    logic [2*SUM_W-1:0]   pp_shifted;
    logic [SUM_W:0]       var_diff;
    logic                 prod_ovf;
    t_div_req             div_req;
    t_div_rsp             div_rsp;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // elapsed time of the incoming stamps less read_delay, wrapped end adds one second
    always_comb begin
        if (i_end_ns < i_begin_ns) begin
            gap = ONE_SECOND_NS - (32'(i_begin_ns) - 32'(i_end_ns));
        end else begin
            gap = 32'(i_end_ns) - 32'(i_begin_ns);
        end
        t_corr      = gap - 32'(r_read_delay);
        elapsed_neg = t_corr[31];
        elapsed_now = elapsed_neg ? '0 : t_corr[TIME_W-1:0];
    end

    // saturating sums and counter
    always_comb begin
        total_add  = {1'b0, r_total} + (SUM_W + 1)'(r_elapsed);
        sumsq_add  = {1'b0, r_sumsq} + {1'b0, mul_product};
        count_full = &r_count;
        count_ext  = SUM_W'(r_count);
        count_m1   = count_ext - SUM_W'(1);
    end

    // divider operands
    always_comb begin
        div_req.start    = (r_state == ST_DIVGO);
        div_req.dividend = r_total;
        div_req.divisor  = count_m1;
        case (r_div_sel)
            DIV_MSQ: begin
                div_req.dividend = r_sumsq;
                div_req.divisor  = count_m1;
            end
            DIV_Q1: begin
                div_req.dividend = r_total;
                div_req.divisor  = count_ext;
            end
            default: begin
                div_req.dividend = r_total;
                div_req.divisor  = count_m1;
            end
        endcase
    end

    // multiplier operands: square of a sample, or partial products of q1 * q2
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ST_SQR) begin
            mul_a = MUL_W'(r_elapsed);
            mul_b = MUL_W'(r_elapsed);
        end else if (r_state == ST_MUL) begin
            mul_a = r_pp[1] ? r_q1[SUM_W-1:MUL_W] : r_q1[MUL_W-1:0];
            mul_b = r_pp[0] ? r_q2[SUM_W-1:MUL_W] : r_q2[MUL_W-1:0];
        end
    end

    // place the previous partial product at its weight
    always_comb begin
        pp_prev = r_pp - 3'd1;
        case (pp_prev[1:0]) inside
            2'd0:       pp_shifted = (2*SUM_W)'(mul_product);
            2'd1, 2'd2: pp_shifted = (2*SUM_W)'(mul_product) << MUL_W;
            default:    pp_shifted = (2*SUM_W)'(mul_product) << (2*MUL_W);
        endcase
    end

    // final variance step
    always_comb begin
        prod_ovf = |r_acc[2*SUM_W-1:SUM_W];
        var_diff = {1'b0, r_msq} - {1'b0, r_acc[SUM_W-1:0]};
    end

    ets_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ets_mul u_mul (
        .i_clk     (i_clk),
        .i_op_a    (mul_a),
        .i_op_b    (mul_b),
        .o_product (mul_product)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_delay <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_read_delay <= i_cfg_read_delay;
        end
    end

    // sequencer, accumulators and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_sumsq     <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_count     <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_elapsed <= (i_action == ACT_SAMPLE) ? elapsed_now : '0;
                        r_flag    <= (i_action == ACT_SAMPLE) && elapsed_neg;
                        r_status  <= ((i_action == ACT_REPORT) && (r_count < COUNT_BITS'(2)))
                                     ? STATUS_FEW : STATUS_OK;
                        r_var     <= '0;
                        r_div_sel <= DIV_MSQ;
                        case (i_action)
                            ACT_CLEAR: begin
                                r_total <= '0;
                                r_sumsq <= '0;
                                r_min   <= '1;
                                r_max   <= '0;
                                r_count <= '0;
                                r_state <= ST_DONE;
                            end
                            ACT_SAMPLE: begin
                                r_state <= ST_SQR;
                            end
                            ACT_REPORT: begin
                                if (r_count < COUNT_BITS'(2)) begin
                                    r_state <= ST_DONE;
                                end else begin
                                    r_state <= ST_DIVGO;
                                end
                            end
                            default: begin
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SQR: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_total <= total_add[SUM_W] ? '1 : total_add[SUM_W-1:0];
                    r_sumsq <= sumsq_add[SUM_W] ? '1 : sumsq_add[SUM_W-1:0];
                    if (r_elapsed < r_min) begin
                        r_min <= r_elapsed;
                    end
                    if (r_elapsed > r_max) begin
                        r_max <= r_elapsed;
                    end
                    if (!count_full) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (r_flag || total_add[SUM_W] || sumsq_add[SUM_W] || count_full) begin
                        r_status <= STATUS_SAT;
                    end
                    r_state <= ST_DONE;
                end
                ST_DIVGO: begin
                    r_state <= ST_DIVWAIT;
                end
                ST_DIVWAIT: begin
                    if (div_rsp.done) begin
                        case (r_div_sel)
                            DIV_MSQ: begin
                                r_msq     <= div_rsp.quotient;
                                r_div_sel <= DIV_Q1;
                                r_state   <= ST_DIVGO;
                            end
                            DIV_Q1: begin
                                r_q1      <= div_rsp.quotient;
                                r_div_sel <= DIV_Q2;
                                r_state   <= ST_DIVGO;
                            end
                            default: begin
                                r_q2    <= div_rsp.quotient;
                                r_pp    <= '0;
                                r_acc   <= '0;
                                r_state <= ST_MUL;
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    if (r_pp != 3'd0) begin
                        r_acc <= r_acc + pp_shifted;
                    end
                    r_pp <= r_pp + 3'd1;
                    if (r_pp == 3'd4) begin
                        r_state <= ST_VAR;
                    end
                end
                ST_VAR: begin
                    if (prod_ovf || var_diff[SUM_W]) begin
                        r_status <= STATUS_SAT;
                        r_var    <= '0;
                    end else begin
                        r_var <= var_diff[SUM_W-1:0];
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_elapsed <= r_elapsed;
                        r_o_total   <= r_total;
                        r_o_sumsq   <= r_sumsq;
                        r_o_min     <= r_min;
                        r_o_max     <= r_max;
                        r_o_count   <= COUNT_W'(r_count);
                        r_o_var     <= r_var;
                        r_o_status  <= r_status;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // ports
    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_elapsed       = r_o_elapsed;
    assign o_running_total = r_o_total;
    assign o_square_sum    = r_o_sumsq;
    assign o_least_time    = r_o_min;
    assign o_greatest_time = r_o_max;
    assign o_count_seen    = r_o_count;
    assign o_variance_out  = r_o_var;
    assign o_status        = r_o_status;

    // an accepted transaction blocks the input until its result is registered
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_in_stall)
        else $error("input not stalled after a transaction was taken");

    // the divider only answers while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIVWAIT))
        else $error("divider finished outside its wait step");

    // an empty accumulator holds the reset extremes and a zero total
    a_empty_extremes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> ((r_min == '1) && (r_max == '0) && (r_total == '0)))
        else $error("extremes or total set with no samples");

    // once samples exist the minimum never exceeds the maximum
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_min <= r_max))
        else $error("minimum above maximum");

    // a report with too few samples carries no variance
    a_few_no_var: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_o_status == STATUS_FEW)) |-> (r_o_var == '0))
        else $error("variance given with too few samples");

endmodule : elapsed_time_statistics

`default_nettype wire
